### rtl/fcm_pkg.sv
package fcm_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int RESULT_CAP  = 8;

   // Field widths.
   localparam int KIND_W    = 3;
   localparam int TEMP_W    = 9;
   localparam int RPM_W     = 14;
   localparam int MAXC_W    = 8;
   localparam int CODE_W    = 16;
   localparam int TIMEOUT_W = 16;
   localparam int SIL_W     = 17;
   localparam int POS_W     = 3;
   localparam int RCNT_W    = 4;

   // Shared compare unit operand width: holds the full silence count as a positive value.
   localparam int CMP_W = SIL_W + 1;

   // Configuration port.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int REG_W  = 3;

   localparam logic [REG_W-1:0] REG_TEMP_LIMIT     = 3'd0;
   localparam logic [REG_W-1:0] REG_RPM_LIMIT      = 3'd1;
   localparam logic [REG_W-1:0] REG_TIMEOUT_MS     = 3'd2;
   localparam logic [REG_W-1:0] REG_CODE_OVERHEAT  = 3'd3;
   localparam logic [REG_W-1:0] REG_CODE_OVERSPEED = 3'd4;
   localparam logic [REG_W-1:0] REG_CODE_LINK_LOST = 3'd5;

   localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST     = 9'sd105;
   localparam logic [RPM_W-1:0]         RPM_LIMIT_RST      = 14'd6500;
   localparam logic [TIMEOUT_W-1:0]     TIMEOUT_MS_RST     = 16'd1000;
   localparam logic [CODE_W-1:0]        CODE_OVERHEAT_RST  = 16'd277;
   localparam logic [CODE_W-1:0]        CODE_OVERSPEED_RST = 16'd537;
   localparam logic [CODE_W-1:0]        CODE_LINK_LOST_RST = 16'd49408;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_TELEMETRY = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LIST      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS    = 3'd4;

   typedef struct packed {
      logic wr_en;
      logic clear;
   } tbl_ctl_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_res_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CMP_TEMP = 7'b0000010,
      ST_CMP_RPM  = 7'b0000100,
      ST_CMP_SIL  = 7'b0001000,
      ST_DISPATCH = 7'b0010000,
      ST_SCAN     = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

endpackage

### rtl/fcm_cmp.sv
module fcm_cmp (
   input  logic signed [fcm_pkg::CMP_W-1:0] opa,
   input  logic signed [fcm_pkg::CMP_W-1:0] opb,
   output fcm_pkg::cmp_res_type             res
);
   import fcm_pkg::*;

   // One signed magnitude compare, shared by the threshold checks and the duplicate scan.
   always_comb begin
      res.gt = (opa > opb);
      res.eq = (opa == opb);
   end

endmodule

### rtl/fcm_table.sv
module fcm_table (
   input  logic                        clock,
   input  logic                        reset,
   input  fcm_pkg::tbl_ctl_type        ctl,
   input  logic [fcm_pkg::CODE_W-1:0]  wr_data,
   input  logic [fcm_pkg::IDX_W-1:0]   rd_idx,
   output logic [fcm_pkg::CODE_W-1:0]  rd_data,
   output logic [fcm_pkg::CNT_W-1:0]   count
);
   import fcm_pkg::*;

   logic [CODE_W-1:0] table_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              append;

   // Codes are appended at the fill count; a full table drops the write.
   assign append = ctl.wr_en && (count_ff < CNT_W'(TABLE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (append && !ctl.clear) begin
         table_ff[count_ff[IDX_W-1:0]] <= wr_data;
      end
   end

   assign rd_data = table_ff[rd_idx];
   assign count   = count_ff;

endmodule

### rtl/fault_code_monitor.sv
// Vehicle fault monitor with an ordered table of diagnostic codes.
//
// Input channel (req_*): one beat carries a kind and its operands. Telemetry compares
// coolant temperature and engine speed with their limits, records the overheat and
// overspeed codes and restarts the millisecond silence counter; a tick advances it,
// saturating; a list query records the link-lost code when silence exceeds the
// timeout and then returns the stored codes in table order; clear empties the table
// and the silence counter; a status query returns one beat with fault_active.
// Result channel (rsp_*): list queries give one beat per returned code (at least one),
// status queries give one beat; last marks the final beat of a query.
// The block works on one item at a time; req_stall is high until the sequencer is back
// in idle. Tick, clear and unknown kinds complete in idle; unknown kinds are dropped.
// Telemetry runs the two threshold compares, then for each code recorded a dispatch
// step and a duplicate scan through the shared compare unit. A list query takes a
// compare, a scan, then emits its result beats while the output register has room.
// Results are loaded from the emit step into an output register, so a stalled
// receiver only holds the emit step; a new item is taken as soon as the last beat is
// loaded. Synchronous reset empties the table, clears the silence counter, drops any
// pending beat and loads the register defaults.
module fault_code_monitor (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fcm_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [fcm_pkg::TEMP_W-1:0]  req_coolant_temp,
   input  logic [fcm_pkg::RPM_W-1:0]          req_engine_rpm,
   input  logic [fcm_pkg::MAXC_W-1:0]         req_list_limit,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fcm_pkg::CODE_W-1:0]         rsp_fault_code,
   output logic [fcm_pkg::POS_W-1:0]          rsp_position,
   output logic                               rsp_code_valid,
   output logic [fcm_pkg::RCNT_W-1:0]         rsp_returned_count,
   output logic                               rsp_fault_active,
   output logic                               rsp_last,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fcm_pkg::ADDR_W-1:0]         paddr,
   input  logic [fcm_pkg::DATA_W-1:0]         pwdata,
   output logic [fcm_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);
   import fcm_pkg::*;

   // ---------------------------------------------------------------------------------
   // Configuration registers. A write lands on the access cycle; pready is tied high.
   // ---------------------------------------------------------------------------------
   logic signed [TEMP_W-1:0] temp_limit_ff;
   logic [RPM_W-1:0]         rpm_limit_ff;
   logic [TIMEOUT_W-1:0]     timeout_ms_ff;
   logic [CODE_W-1:0]        code_overheat_ff;
   logic [CODE_W-1:0]        code_overspeed_ff;
   logic [CODE_W-1:0]        code_link_lost_ff;
   logic                     cfg_wr;
   logic [REG_W-1:0]         cfg_reg;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_reg = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_limit_ff     <= TEMP_LIMIT_RST;
         rpm_limit_ff      <= RPM_LIMIT_RST;
         timeout_ms_ff     <= TIMEOUT_MS_RST;
         code_overheat_ff  <= CODE_OVERHEAT_RST;
         code_overspeed_ff <= CODE_OVERSPEED_RST;
         code_link_lost_ff <= CODE_LINK_LOST_RST;
      end else if (cfg_wr) begin
         unique case (cfg_reg)
            REG_TEMP_LIMIT:     temp_limit_ff     <= pwdata[TEMP_W-1:0];
            REG_RPM_LIMIT:      rpm_limit_ff      <= pwdata[RPM_W-1:0];
            REG_TIMEOUT_MS:     timeout_ms_ff     <= pwdata[TIMEOUT_W-1:0];
            REG_CODE_OVERHEAT:  code_overheat_ff  <= pwdata[CODE_W-1:0];
            REG_CODE_OVERSPEED: code_overspeed_ff <= pwdata[CODE_W-1:0];
            REG_CODE_LINK_LOST: code_link_lost_ff <= pwdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Reads return the register value; the temperature limit is sign extended.
   always_comb begin
      prdata = '0;
      unique case (cfg_reg)
         REG_TEMP_LIMIT:
            prdata = {{(DATA_W-TEMP_W){temp_limit_ff[TEMP_W-1]}}, temp_limit_ff};
         REG_RPM_LIMIT:      prdata = DATA_W'(rpm_limit_ff);
         REG_TIMEOUT_MS:     prdata = DATA_W'(timeout_ms_ff);
         REG_CODE_OVERHEAT:  prdata = DATA_W'(code_overheat_ff);
         REG_CODE_OVERSPEED: prdata = DATA_W'(code_overspeed_ff);
         REG_CODE_LINK_LOST: prdata = DATA_W'(code_link_lost_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Sequencer state and captured item.
   // ---------------------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [RPM_W-1:0]         rpm_ff, rpm_in;
   logic [MAXC_W-1:0]        maxc_ff, maxc_in;
   logic                     pend_heat_ff, pend_heat_in;
   logic                     pend_speed_ff, pend_speed_in;
   logic                     pend_link_ff, pend_link_in;
   logic [CODE_W-1:0]        rec_code_ff, rec_code_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [RCNT_W-1:0]        num_ff, num_in;
   logic [SIL_W-1:0]         silence_ff, silence_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]        rsp_code_ff, rsp_code_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_cvalid_ff, rsp_cvalid_in;
   logic [RCNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                     rsp_active_ff, rsp_active_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Table and shared compare unit.
   tbl_ctl_type              tbl_ctl;
   logic [CODE_W-1:0]        tbl_rd_data;
   logic [CNT_W-1:0]         tbl_count;
   logic signed [CMP_W-1:0]  cmp_a, cmp_b;
   cmp_res_type              cmp_res;

   logic                     req_take;
   logic                     slot_free;
   logic [MAXC_W-1:0]        list_len;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // The output register can take a beat when empty or when its beat leaves this edge.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Number of codes a list query returns: least of fill count, list limit and the cap.
   always_comb begin
      list_len = MAXC_W'(tbl_count);
      if (maxc_ff < list_len) begin
         list_len = maxc_ff;
      end
      if (list_len > MAXC_W'(RESULT_CAP)) begin
         list_len = MAXC_W'(RESULT_CAP);
      end
   end

   fcm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .wr_data (rec_code_ff),
      .rd_idx  (idx_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data),
      .count   (tbl_count)
   );

   fcm_cmp u_cmp (
      .opa (cmp_a),
      .opb (cmp_b),
      .res (cmp_res)
   );

   // Operand selection for the shared compare unit.
   always_comb begin
      cmp_a = CMP_W'(tbl_rd_data);
      cmp_b = CMP_W'(rec_code_ff);
      unique case (state_ff)
         ST_CMP_TEMP: begin
            cmp_a = {{(CMP_W-TEMP_W){temp_ff[TEMP_W-1]}}, temp_ff};
            cmp_b = {{(CMP_W-TEMP_W){temp_limit_ff[TEMP_W-1]}}, temp_limit_ff};
         end
         ST_CMP_RPM: begin
            cmp_a = CMP_W'(rpm_ff);
            cmp_b = CMP_W'(rpm_limit_ff);
         end
         ST_CMP_SIL: begin
            cmp_a = CMP_W'(silence_ff);
            cmp_b = CMP_W'(timeout_ms_ff);
         end
         default: ;
      endcase
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      temp_in       = temp_ff;
      rpm_in        = rpm_ff;
      maxc_in       = maxc_ff;
      pend_heat_in  = pend_heat_ff;
      pend_speed_in = pend_speed_ff;
      pend_link_in  = pend_link_ff;
      rec_code_in   = rec_code_ff;
      idx_in        = idx_ff;
      num_in        = num_ff;
      silence_in    = silence_ff;
      tbl_ctl       = '0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in = req_kind;
               temp_in = req_coolant_temp;
               rpm_in  = req_engine_rpm;
               maxc_in = req_list_limit;
               case (req_kind)
                  KIND_TELEMETRY: begin
                     silence_in = '0;
                     state_in   = ST_CMP_TEMP;
                  end
                  KIND_TICK: begin
                     if (silence_ff != '1) begin
                        silence_in = silence_ff + SIL_W'(1);
                     end
                  end
                  KIND_LIST: begin
                     state_in = ST_CMP_SIL;
                  end
                  KIND_CLEAR: begin
                     tbl_ctl.clear = 1'b1;
                     silence_in    = '0;
                  end
                  KIND_STATUS: begin
                     num_in   = '0;
                     idx_in   = '0;
                     state_in = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end

         ST_CMP_TEMP: begin
            pend_heat_in = cmp_res.gt;
            state_in     = ST_CMP_RPM;
         end

         ST_CMP_RPM: begin
            pend_speed_in = cmp_res.gt;
            pend_link_in  = 1'b0;
            state_in      = ST_DISPATCH;
         end

         ST_CMP_SIL: begin
            pend_heat_in  = 1'b0;
            pend_speed_in = 1'b0;
            pend_link_in  = cmp_res.gt;
            state_in      = ST_DISPATCH;
         end

         // Pick the next code to record, in overheat, overspeed, link-lost order.
         ST_DISPATCH: begin
            idx_in = '0;
            if (pend_heat_ff) begin
               pend_heat_in = 1'b0;
               rec_code_in  = code_overheat_ff;
               state_in     = ST_SCAN;
            end else if (pend_speed_ff) begin
               pend_speed_in = 1'b0;
               rec_code_in   = code_overspeed_ff;
               state_in      = ST_SCAN;
            end else if (pend_link_ff) begin
               pend_link_in = 1'b0;
               rec_code_in  = code_link_lost_ff;
               state_in     = ST_SCAN;
            end else if (kind_ff == KIND_LIST) begin
               num_in   = RCNT_W'(list_len);
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // Walk the stored codes one per cycle; append at the end if no match was found.
         ST_SCAN: begin
            if (idx_ff == tbl_count) begin
               tbl_ctl.wr_en = 1'b1;
               state_in      = ST_DISPATCH;
            end else if (cmp_res.eq) begin
               state_in = ST_DISPATCH;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // One result beat per cycle while the output register has room.
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_active_in = (tbl_count != '0);
               if (num_ff == '0) begin
                  rsp_code_in   = '0;
                  rsp_pos_in    = '0;
                  rsp_cvalid_in = 1'b0;
                  rsp_cnt_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  rsp_code_in   = tbl_rd_data;
                  rsp_pos_in    = POS_W'(idx_ff);
                  rsp_cvalid_in = 1'b1;
                  rsp_cnt_in    = num_ff;
                  rsp_last_in   = (RCNT_W'(idx_ff) + RCNT_W'(1) == num_ff);
                  idx_in        = idx_ff + CNT_W'(1);
                  if (RCNT_W'(idx_ff) + RCNT_W'(1) == num_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_heat_ff  <= 1'b0;
         pend_speed_ff <= 1'b0;
         pend_link_ff  <= 1'b0;
         silence_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_heat_ff  <= pend_heat_in;
         pend_speed_ff <= pend_speed_in;
         pend_link_ff  <= pend_link_in;
         silence_ff    <= silence_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers carry no reset.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      temp_ff       <= temp_in;
      rpm_ff        <= rpm_in;
      maxc_ff       <= maxc_in;
      rec_code_ff   <= rec_code_in;
      idx_ff        <= idx_in;
      num_ff        <= num_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fault_code     = rsp_code_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_code_valid     = rsp_cvalid_ff;
   assign rsp_returned_count = rsp_cnt_ff;
   assign rsp_fault_active   = rsp_active_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

### rtl/fcm_checker.sv
module fcm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [fcm_pkg::CODE_W-1:0]         rsp_fault_code,
   input logic [fcm_pkg::POS_W-1:0]          rsp_position,
   input logic                               rsp_code_valid,
   input logic [fcm_pkg::RCNT_W-1:0]         rsp_returned_count,
   input logic                               rsp_fault_active,
   input logic                               rsp_last
);
   import fcm_pkg::*;

   // A stalled beat stays and keeps its code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fault_code) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // An empty beat is always the single, final beat of its query.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_code_valid |->
         rsp_last && (rsp_returned_count == '0) && (rsp_fault_code == '0)
         && (rsp_position == '0))
      else $error("empty result beat malformed");

   // A beat with a code lies inside its list and implies a nonempty table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_valid |->
         rsp_fault_active && (RCNT_W'(rsp_position) < rsp_returned_count)
         && (rsp_last == (RCNT_W'(rsp_position) + RCNT_W'(1) == rsp_returned_count)))
      else $error("result beat position out of list");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind fault_code_monitor fcm_checker u_fcm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_fault_code     (rsp_fault_code),
   .rsp_position       (rsp_position),
   .rsp_code_valid     (rsp_code_valid),
   .rsp_returned_count (rsp_returned_count),
   .rsp_fault_active   (rsp_fault_active),
   .rsp_last           (rsp_last)
);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fcm_pkg::*;

   // Lowest and highest reserved kinds. The block must drop them without a beat.
   localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

   localparam logic [SIL_W-1:0] SILENCE_CEIL = '1;

   // Cycles allowed after the last beat for an item that returns nothing to finish.
   // Telemetry with two recorded codes is the slowest of those.
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [TEMP_W-1:0] temp;
      logic [RPM_W-1:0]         rpm;
      logic [MAXC_W-1:0]        list_limit;
   } fault_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] fault_code;
      logic [POS_W-1:0]  position;
      logic              code_valid;
      logic [RCNT_W-1:0] returned_count;
      logic              fault_active;
      logic              last;
   } fault_report_type;

   typedef struct {
      fault_item_type   item;
      bit               typed;
      fault_report_type report;
   } directed_row_type;

   localparam fault_report_type NO_REPORT    = '0;
   localparam fault_report_type EMPTY_IDLE   = '{16'd0, 3'd0, 1'b0, 4'd0, 1'b0, 1'b1};
   localparam fault_report_type EMPTY_ACTIVE = '{16'd0, 3'd0, 1'b0, 4'd0, 1'b1, 1'b1};
   localparam fault_report_type HEAT_ONLY    =
      '{CODE_OVERHEAT_RST, 3'd0, 1'b1, 4'd1, 1'b1, 1'b1};
   localparam fault_report_type SPEED_ONLY   =
      '{CODE_OVERSPEED_RST, 3'd0, 1'b1, 4'd1, 1'b1, 1'b1};

   // Directed opening, run with the reset settings. Rows with a typed report return
   // exactly one beat whose value follows directly from the reset limits and codes.
   directed_row_type directed_rows [19] = '{
      '{'{KIND_STATUS,      9'sd0,   14'd0,     8'd0},   1'b1, EMPTY_IDLE},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd255}, 1'b1, EMPTY_IDLE},
      '{'{KIND_TELEMETRY,   -9'sd40, 14'd0,     8'd0},   1'b0, NO_REPORT},
      '{'{KIND_TELEMETRY,   9'sd105, 14'd6500,  8'd0},   1'b0, NO_REPORT},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd8},   1'b1, EMPTY_IDLE},
      '{'{KIND_TELEMETRY,   9'sd106, 14'd0,     8'd0},   1'b0, NO_REPORT},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd1},   1'b1, HEAT_ONLY},
      '{'{KIND_TELEMETRY,   9'sd215, 14'd16383, 8'd0},   1'b0, NO_REPORT},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd0},   1'b1, EMPTY_ACTIVE},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd255}, 1'b0, NO_REPORT},
      '{'{KIND_STATUS,      9'sd0,   14'd0,     8'd0},   1'b1, EMPTY_ACTIVE},
      '{'{KIND_TICK,        9'sd0,   14'd0,     8'd0},   1'b0, NO_REPORT},
      '{'{KIND_CLEAR,       9'sd0,   14'd0,     8'd0},   1'b0, NO_REPORT},
      '{'{KIND_RESERVED_HI, -9'sd1,  14'd16383, 8'd255}, 1'b0, NO_REPORT},
      '{'{KIND_RESERVED_LO, 9'sd200, 14'd0,     8'd255}, 1'b0, NO_REPORT},
      '{'{KIND_STATUS,      9'sd0,   14'd0,     8'd0},   1'b1, EMPTY_IDLE},
      '{'{KIND_TELEMETRY,   -9'sd1,  14'd6501,  8'd0},   1'b0, NO_REPORT},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd1},   1'b1, SPEED_ONLY},
      '{'{KIND_LIST,        9'sd0,   14'd0,     8'd9},   1'b0, NO_REPORT}
   };

   // Ports of the block.
   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind;
   logic signed [TEMP_W-1:0] req_coolant_temp;
   logic [RPM_W-1:0]         req_engine_rpm;
   logic [MAXC_W-1:0]        req_list_limit;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [CODE_W-1:0]        rsp_fault_code;
   logic [POS_W-1:0]         rsp_position;
   logic                     rsp_code_valid;
   logic [RCNT_W-1:0]        rsp_returned_count;
   logic                     rsp_fault_active;
   logic                     rsp_last;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [ADDR_W-1:0]        paddr;
   logic [DATA_W-1:0]        pwdata;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // Shadow of the block: the code store, its fill count, the silence counter and the
   // six settings, kept in step with every accepted beat and every register write.
   logic [CODE_W-1:0]        code_store [TABLE_DEPTH];
   logic [CNT_W-1:0]         code_count;
   logic [SIL_W-1:0]         silence_ms;
   logic signed [TEMP_W-1:0] lim_temp;
   logic [RPM_W-1:0]         lim_rpm;
   logic [TIMEOUT_W-1:0]     lim_timeout;
   logic [CODE_W-1:0]        code_heat;
   logic [CODE_W-1:0]        code_speed;
   logic [CODE_W-1:0]        code_link;

   // Reports the block still owes, oldest first, and those produced by the last item.
   fault_report_type fault_reports [$];
   fault_report_type new_reports [$];

   int  sender_idle_pct = 0;
   int  rsp_stall_pct   = 0;
   bit  hold_request    = 1'b0;
   int  error_count     = 0;
   int  idle_cycles     = 0;
   int  n_items         = 0;
   int  n_beats         = 0;
   int  n_dropped       = 0;
   int  n_link_lost     = 0;

   fault_code_monitor DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Records one code in the shadow store: a code already held is ignored, and a code
   // that finds the store full is dropped.
   function automatic void log_code(input logic [CODE_W-1:0] code);
      bit present;
      present = 1'b0;
      for (int i = 0; i < code_count; i++) begin
         if (code_store[i] == code) present = 1'b1;
      end
      if (!present) begin
         if (code_count < TABLE_DEPTH) begin
            code_store[code_count[IDX_W-1:0]] = code;
            code_count = code_count + 1'b1;
         end else begin
            n_dropped++;
         end
      end
   endfunction

   // Advances the shadow by one accepted item and leaves its reports in new_reports.
   function automatic void update_fault_table(input fault_item_type it);
      int               n;
      fault_report_type r;
      new_reports.delete();
      r = EMPTY_IDLE;
      case (it.kind)
         KIND_TELEMETRY: begin
            silence_ms = '0;
            if (it.temp > lim_temp) log_code(code_heat);
            if (it.rpm > lim_rpm) log_code(code_speed);
         end
         KIND_TICK: begin
            if (silence_ms != SILENCE_CEIL) silence_ms = silence_ms + 1'b1;
         end
         KIND_LIST: begin
            if (silence_ms > lim_timeout) begin
               n_link_lost++;
               log_code(code_link);
            end
            n = code_count;
            if (it.list_limit < n) n = it.list_limit;
            if (n > RESULT_CAP) n = RESULT_CAP;
            if (n == 0) begin
               r.fault_active = (code_count != 0);
               new_reports.push_back(r);
            end else begin
               for (int i = 0; i < n; i++) begin
                  r.fault_code     = code_store[i];
                  r.position       = i[POS_W-1:0];
                  r.code_valid     = 1'b1;
                  r.returned_count = n[RCNT_W-1:0];
                  r.fault_active   = 1'b1;
                  r.last           = (i + 1 == n);
                  new_reports.push_back(r);
               end
            end
         end
         KIND_CLEAR: begin
            code_count = '0;
            silence_ms = '0;
         end
         KIND_STATUS: begin
            r.fault_active = (code_count != 0);
            new_reports.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // Draws one random item. Temperatures and speeds sit next to the current limits
   // half of the time so that both sides of each compare come up often.
   function automatic fault_item_type random_item();
      fault_item_type it;
      int             w;
      int             t;
      int             s;
      w = $urandom_range(99);
      if (w < 35) it.kind = KIND_TELEMETRY;
      else if (w < 55) it.kind = KIND_TICK;
      else if (w < 80) it.kind = KIND_LIST;
      else if (w < 85) it.kind = KIND_CLEAR;
      else if (w < 95) it.kind = KIND_STATUS;
      else it.kind = KIND_W'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
      if ($urandom_range(1)) begin
         t = int'(lim_temp) + int'($urandom_range(6)) - 3;
         if (t < -40) t = -40;
         if (t > 215) t = 215;
      end else begin
         t = int'($urandom_range(255)) - 40;
      end
      if ($urandom_range(1)) begin
         s = int'(lim_rpm) + int'($urandom_range(6)) - 3;
         if (s < 0) s = 0;
         if (s > 16383) s = 16383;
      end else begin
         s = $urandom_range(16383);
      end
      it.temp = t[TEMP_W-1:0];
      it.rpm  = s[RPM_W-1:0];
      w = $urandom_range(99);
      if (w < 60) it.list_limit = MAXC_W'($urandom_range(9));
      else if (w < 80) it.list_limit = 8'd255;
      else it.list_limit = MAXC_W'($urandom_range(255));
      return it;
   endfunction

   // Offers one beat, with a random gap in front of it, and holds it until the block
   // takes it. The shadow is advanced at the accepting edge. A typed report, where
   // given, stands in for what the shadow produced.
   task automatic offer_item(input fault_item_type it, input bit typed,
                             input fault_report_type typed_report);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= it.kind;
      req_coolant_temp <= it.temp;
      req_engine_rpm   <= it.rpm;
      req_list_limit   <= it.list_limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_fault_table(it);
      if (typed) fault_reports.push_back(typed_report);
      else foreach (new_reports[i]) fault_reports.push_back(new_reports[i]);
      n_items++;
   endtask

   // Stops offering, waits for every owed beat, then lets the block finish any item
   // that returns nothing. The block is idle afterwards.
   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fault_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle; the write lands at the edge
   // where the access phase meets pready.
   task automatic write_register(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_TEMP_LIMIT:     lim_temp    = value[TEMP_W-1:0];
         REG_RPM_LIMIT:      lim_rpm     = value[RPM_W-1:0];
         REG_TIMEOUT_MS:     lim_timeout = value[TIMEOUT_W-1:0];
         REG_CODE_OVERHEAT:  code_heat   = value[CODE_W-1:0];
         REG_CODE_OVERSPEED: code_speed  = value[CODE_W-1:0];
         REG_CODE_LINK_LOST: code_link   = value[CODE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes all six registers. Only called while the block is idle.
   task automatic load_settings(input int temp, input int rpm, input int timeout,
                                input int heat, input int speed, input int link);
      write_register(REG_TEMP_LIMIT, temp);
      write_register(REG_RPM_LIMIT, rpm);
      write_register(REG_TIMEOUT_MS, timeout);
      write_register(REG_CODE_OVERHEAT, heat);
      write_register(REG_CODE_OVERSPEED, speed);
      write_register(REG_CODE_LINK_LOST, link);
   endtask

   task automatic run_random(input int count);
      repeat (count) offer_item(random_item(), 1'b0, NO_REPORT);
   endtask

   task automatic offer_simple(input logic [KIND_W-1:0] kind, input int temp, input int rpm,
                               input int list_limit);
      fault_item_type it;
      it.kind       = kind;
      it.temp       = temp[TEMP_W-1:0];
      it.rpm        = rpm[RPM_W-1:0];
      it.list_limit = list_limit[MAXC_W-1:0];
      offer_item(it, 1'b0, NO_REPORT);
   endtask

   task automatic check_field(input string name, input int unsigned expv,
                              input int unsigned actv);
      if (expv != actv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         error_count++;
      end
   endtask

   // Receiver. Normally it stalls at random; on request it holds off for a long
   // stretch so that the output register fills and the block stalls its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Every accepted result beat is matched against the oldest owed report.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_beats++;
         if (fault_reports.size() == 0) begin
            $error("unexpected result beat: fault_code %0d position %0d",
                   rsp_fault_code, rsp_position);
            error_count++;
         end else begin
            check_field("fault_code", fault_reports[0].fault_code, rsp_fault_code);
            check_field("position", fault_reports[0].position, rsp_position);
            check_field("code_valid", fault_reports[0].code_valid, rsp_code_valid);
            check_field("returned_count", fault_reports[0].returned_count,
                        rsp_returned_count);
            check_field("fault_active", fault_reports[0].fault_active, rsp_fault_active);
            check_field("last", fault_reports[0].last, rsp_last);
            void'(fault_reports.pop_front());
         end
      end
   end

   // Watchdog: a run in which neither channel moves a beat for too long is hung.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_TELEMETRY;
      req_coolant_temp = '0;
      req_engine_rpm   = '0;
      req_list_limit   = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      code_count       = '0;
      silence_ms       = '0;
      lim_temp         = TEMP_LIMIT_RST;
      lim_rpm          = RPM_LIMIT_RST;
      lim_timeout      = TIMEOUT_MS_RST;
      code_heat        = CODE_OVERHEAT_RST;
      code_speed       = CODE_OVERSPEED_RST;
      code_link        = CODE_LINK_LOST_RST;
      foreach (code_store[i]) code_store[i] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First idling mode: the sender rarely idles, the receiver stalls more often
      // than not.
      sender_idle_pct = 10;
      rsp_stall_pct   = 58;

      foreach (directed_rows[i])
         offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].report);
      pause_sender();

      // Fill the store. Each round installs new code values without clearing, so the
      // store reaches eight entries and later codes are dropped. In the first round
      // the link-lost code equals the overheat code, which must count as a duplicate.
      // The limits sit at their lower extremes so that every telemetry beat trips both.
      for (int round = 0; round < 4; round++) begin
         if (round == 0) load_settings(-40, 0, 1, 0, 16'hFFFF, 0);
         else load_settings(-40, 0, 1, 16'h1000 + round * 3, 16'h2001 + round * 3,
                            16'h4002 + round * 3);
         offer_simple(KIND_TELEMETRY, 215, 16383, 0);
         offer_simple(KIND_TICK, 0, 0, 0);
         offer_simple(KIND_TICK, 0, 0, 0);
         offer_simple(KIND_LIST, 0, 0, 255);
         pause_sender();
      end
      offer_simple(KIND_LIST, 0, 0, 8);
      offer_simple(KIND_LIST, 0, 0, 7);

      // Long receiver hold-off while full-length list queries keep coming: the output
      // register fills and the block has to stall its input.
      hold_request = 1'b1;
      repeat (6) offer_simple(KIND_LIST, 0, 0, 255);
      pause_sender();

      load_settings(0, 8000, 2, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                    $urandom_range(16'hFFFF));
      offer_simple(KIND_CLEAR, 0, 0, 0);
      run_random(20);
      pause_sender();

      // Second idling mode, with the limits at their upper extremes: telemetry can
      // never trip, so only the link-lost code fills the store.
      sender_idle_pct = 58;
      rsp_stall_pct   = 10;
      load_settings(215, 16383, 1, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                    $urandom_range(16'hFFFF));
      run_random(15);
      pause_sender();

      // No idling at all, with fully random settings.
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      load_settings(int'($urandom_range(255)) - 40, $urandom_range(16383),
                    $urandom_range(6, 1), $urandom_range(16'hFFFF),
                    $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
      run_random(15);
      pause_sender();

      // Let the silence counter run just past the timeout so that the list query
      // records the link-lost code, then restart it with telemetry and query again.
      load_settings(0, 8000, 3, 16'h0111, 16'h0222, 16'h0333);
      offer_simple(KIND_CLEAR, 0, 0, 0);
      repeat (4) offer_simple(KIND_TICK, 0, 0, 0);
      offer_simple(KIND_LIST, 0, 0, 255);
      offer_simple(KIND_TELEMETRY, -40, 0, 0);
      repeat (3) offer_simple(KIND_TICK, 0, 0, 0);
      offer_simple(KIND_LIST, 0, 0, 255);
      offer_simple(KIND_STATUS, 0, 0, 0);
      pause_sender();

      $display("summary: %0d items accepted, %0d result beats compared, %0d link-lost hits",
               n_items, n_beats, n_link_lost);
      $display("summary: %0d codes dropped by a full store, reserved kinds and stalls seen",
               n_dropped);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
